>>> sv/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// shared types and constants of the button debounce and press classifier
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int NUM_BUTTONS  = 3;
    localparam int CNT_W        = 8;
    localparam int HOLD_W       = 16;
    localparam int S_TDATA_W    = ((NUM_BUTTONS + 7) / 8) * 8;
    localparam int M_FIELDS_W   = 3 * NUM_BUTTONS;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_DEBOUNCE_SAMPLES = 2'd0,
        REG_LONG_PRESS_TICKS = 2'd1,
        REG_ACTIVE_LOW       = 2'd2,
        REG_UNUSED           = 2'd3
    } reg_idx_t;

    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET   = 8'd6;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd160;
    localparam logic              ACTIVE_LOW_RESET = 1'b1;

    // settings as seen by the lanes
    typedef struct packed {
        logic [CNT_W-1:0]  limit;
        logic [HOLD_W-1:0] long_ticks;
        logic              active_low;
    } lane_cfg_t;

    // what one lane reports for one tick
    typedef struct packed {
        logic short_press;
        logic long_press;
        logic pressed;
    } lane_evt_t;

endpackage

>>> sv/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// integrating debounce with short and long press detection per button
// ----------------------------------------------------------------------------
// usage
//   s_* carries one poll tick per request: s_tdata[2:0] holds the raw pin
//   level of each button. m_* returns one result per tick with the short
//   press, long press and debounced pressed masks of that tick.
//   the apb port sets the debounce limit, the long press threshold and the
//   pin polarity; write it only while no tick is in flight.
// timing
//   one lane per button updates its counters in the cycle a tick is taken;
//   the merged result sits in the output register on the next cycle, and
//   one tick is taken every cycle unless a result waits on m_tready.
// reset
//   all counters and flags clear, settings return to 6 / 160 / active low.
// stall
//   while m_tready is low with a result waiting, s_tready drops and the
//   button state holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // tick input: [2:0] raw_levels
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result output: [2:0] short_press_mask, [5:3] long_press_mask,
    // [8:6] pressed_mask
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic [CNT_W-1:0]  debounce_samples_reg;
    logic [HOLD_W-1:0] long_press_ticks_reg;
    logic              active_low_reg;
    reg_idx_t          reg_idx;
    logic              wr_en;
    lane_cfg_t         cfg;
    logic              room;
    logic              tick;
    lane_evt_t         evt [NUM_BUTTONS];

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_samples_reg <= DEBOUNCE_RESET;
            long_press_ticks_reg <= LONG_PRESS_RESET;
            active_low_reg       <= ACTIVE_LOW_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEBOUNCE_SAMPLES: debounce_samples_reg <= pwdata[CNT_W-1:0];
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= pwdata[HOLD_W-1:0];
                REG_ACTIVE_LOW:       active_low_reg       <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEBOUNCE_SAMPLES: prdata = APB_DATA_W'(debounce_samples_reg);
            REG_LONG_PRESS_TICKS: prdata = APB_DATA_W'(long_press_ticks_reg);
            REG_ACTIVE_LOW:       prdata = APB_DATA_W'(active_low_reg);
            default:              prdata = '0;
        endcase
    end

    // a limit of zero behaves as one
    assign cfg.limit      = (debounce_samples_reg == '0) ? CNT_W'(1) : debounce_samples_reg;
    assign cfg.long_ticks = long_press_ticks_reg;
    assign cfg.active_low = active_low_reg;

    // ---------------- tick handshake ----------------
    assign s_tready = room;
    assign tick     = s_tvalid && room;

    // ---------------- one lane per button ----------------
    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        bdpc_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .tick      (tick),
            .raw_level (s_tdata[b]),
            .cfg       (cfg),
            .evt       (evt[b])
        );
    end

    // ---------------- merge and output register ----------------
    bdpc_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .evt      (evt),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sv/bdpc_lane.sv
// ----------------------------------------------------------------------------
// bdpc_lane
// debounce counter and press classification of one button
// ----------------------------------------------------------------------------
module bdpc_lane
    import bdpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tick,
    input  logic      raw_level,
    input  lane_cfg_t cfg,
    output lane_evt_t evt
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pressed_reg, pressed_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              long_rep_reg, long_rep_next;
    logic              asserted;
    logic [CNT_W-1:0]  cnt_inc;
    logic [HOLD_W-1:0] hold_inc;

    assign asserted = raw_level ^ cfg.active_low;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign hold_inc = (hold_reg == {HOLD_W{1'b1}}) ? hold_reg : hold_reg + 1'b1;

    always_comb
    begin
        cnt_next        = cnt_reg;
        pressed_next    = pressed_reg;
        hold_next       = hold_reg;
        long_rep_next   = long_rep_reg;
        evt.short_press = 1'b0;
        evt.long_press  = 1'b0;
        if (asserted)
        begin
            if (cnt_reg < cfg.limit)
            begin
                cnt_next = cnt_inc;
                if ((cnt_inc >= cfg.limit) && !pressed_reg)
                begin
                    pressed_next  = 1'b1;
                    hold_next     = '0;
                    long_rep_next = 1'b0;
                end
            end
            else if (!pressed_reg)
            begin
                // limit lowered to or below the count: accept at once
                pressed_next  = 1'b1;
                hold_next     = '0;
                long_rep_next = 1'b0;
            end
            else
            begin
                hold_next = hold_inc;
                if (!long_rep_reg && (hold_inc >= cfg.long_ticks))
                begin
                    long_rep_next  = 1'b1;
                    evt.long_press = 1'b1;
                end
            end
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if ((cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1}) && pressed_reg)
            begin
                pressed_next    = 1'b0;
                evt.short_press = !long_rep_reg;
            end
        end
        evt.pressed = pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pressed_reg  <= 1'b0;
            hold_reg     <= '0;
            long_rep_reg <= 1'b0;
        end
        else if (tick)
        begin
            cnt_reg      <= cnt_next;
            pressed_reg  <= pressed_next;
            hold_reg     <= hold_next;
            long_rep_reg <= long_rep_next;
        end
    end

endmodule

>>> sv/bdpc_merge.sv
// ----------------------------------------------------------------------------
// bdpc_merge
// gathers the lane reports into one result and holds it for the receiver
// ----------------------------------------------------------------------------
module bdpc_merge
    import bdpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  lane_evt_t            evt [NUM_BUTTONS],
    output logic                 room,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                   valid_reg;
    logic [M_FIELDS_W-1:0]  data_reg, data_next;
    logic [NUM_BUTTONS-1:0] shorts, longs, pressed;

    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            shorts[b]  = evt[b].short_press;
            longs[b]   = evt[b].long_press;
            pressed[b] = evt[b].pressed;
        end
        data_next = {pressed, longs, shorts};
    end

    // the output register can take a new result when empty or being drained
    assign room     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'(data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            data_reg <= data_next;
        end
    end

endmodule
